// ----- sv/mpfb_pkg.sv -----
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared codes, constants and types of the monochrome page frame buffer.
// ----------------------------------------------------------------------------
package mpfb_pkg;

  localparam logic [1:0] CMD_DRAW    = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_REFRESH = 2'd2;

  localparam int ROWS_PER_PAGE = 8;
  localparam int PAGE_SHIFT    = 3;

  // coordinates up to 511 inclusive
  localparam int COORD_W = 9;
  localparam int LIN_W   = 2 * COORD_W;

  localparam logic [7:0] LCD_ROW_ADDR = 8'h40;
  localparam logic [7:0] LCD_COL_ADDR = 8'h80;

  typedef struct packed {
    logic       hit;
    logic [2:0] row_bit;
  } pix_loc_t;

endpackage

// ----- sv/mpfb_map.sv -----
// ----------------------------------------------------------------------------
// mpfb_map
// Rotates a pixel coordinate, checks it against the rotated panel size and
// gives the store address and bit of the pixel.
// ----------------------------------------------------------------------------
module mpfb_map #(
  parameter int PANEL_WIDTH  = 84,
  parameter int PANEL_HEIGHT = 48
) (
  input  logic [1:0]                                  rotation,
  input  logic [6:0]                                  pos_x,
  input  logic [6:0]                                  pos_y,
  output mpfb_pkg::pix_loc_t                          loc,
  output logic [$clog2(PANEL_WIDTH*(PANEL_HEIGHT/8))-1:0] addr
);
  import mpfb_pkg::*;

  localparam int PAGE_COUNT = PANEL_HEIGHT / ROWS_PER_PAGE;
  localparam int STORE_SIZE = PANEL_WIDTH * PAGE_COUNT;
  localparam int AW         = $clog2(STORE_SIZE);

  localparam logic [COORD_W-1:0] PW   = COORD_W'(PANEL_WIDTH);
  localparam logic [COORD_W-1:0] PH   = COORD_W'(PANEL_HEIGHT);
  localparam logic [COORD_W-1:0] PWM1 = COORD_W'(PANEL_WIDTH - 1);
  localparam logic [COORD_W-1:0] PHM1 = COORD_W'(PANEL_HEIGHT - 1);

  logic [COORD_W-1:0] x, y, lw, lh, px, py;
  logic [LIN_W-1:0]   lin;
  logic               in_bounds;

  assign x = COORD_W'(pos_x);
  assign y = COORD_W'(pos_y);

  always_comb begin
    lw = rotation[0] ? PH : PW;
    lh = rotation[0] ? PW : PH;
    in_bounds = (x < lw) && (y < lh);
    unique case (rotation)
      2'd1: begin
        px = y;
        py = PHM1 - x;
      end
      2'd2: begin
        px = PWM1 - x;
        py = PHM1 - y;
      end
      2'd3: begin
        px = PWM1 - y;
        py = x;
      end
      default: begin
        px = x;
        py = y;
      end
    endcase
    lin = (LIN_W'(py >> PAGE_SHIFT) * LIN_W'(PANEL_WIDTH)) + LIN_W'(px);
  end

  // partial bottom page falls outside the store
  assign loc.hit     = in_bounds && (lin < LIN_W'(STORE_SIZE));
  assign loc.row_bit = py[2:0];
  assign addr        = lin[AW-1:0];

endmodule

// ----- sv/monochrome_page_framebuffer_unit.sv -----
// ----------------------------------------------------------------------------
// monochrome_page_framebuffer_unit
// Page-organised 1-bit frame buffer with pixel draw, raw byte load and a
// serial refresh byte stream for a page-addressed LCD controller.
//
//   port group   role      transfer
//   req_*        in        draw / load / refresh item on req_valid & req_ready
//   spi_*        out       refresh byte on spi_valid & spi_ready
//   APB          config    rotation register at address 0
//
// Load, dropped draw and refresh command items leave the unit in S_IDLE; a
// plotted draw (read-modify-write) and a refresh data byte pass through S_RMW
// or S_DATA, bound by the single store port.
// After reset a clearing pass writes zero to every store byte, one a cycle,
// with req_ready low.
// A refresh item waits while an earlier byte is still held on spi_*;
// draw and load items do not.
// ----------------------------------------------------------------------------
module monochrome_page_framebuffer_unit #(
  parameter int PANEL_WIDTH  = 84,
  parameter int PANEL_HEIGHT = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  cmd,
  input  logic [6:0]  pos_x,
  input  logic [6:0]  pos_y,
  input  logic        color,
  input  logic [8:0]  byte_index,
  input  logic [7:0]  byte_value,
  output logic        spi_valid,
  input  logic        spi_ready,
  output logic [7:0]  spi_byte,
  output logic        is_data,
  output logic        frame_last
);
  import mpfb_pkg::*;

  localparam int PAGE_COUNT = PANEL_HEIGHT / ROWS_PER_PAGE;
  localparam int STORE_SIZE = PANEL_WIDTH * PAGE_COUNT;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int PG_W       = $clog2(PAGE_COUNT + 1);
  localparam int OFF_W      = $clog2(PANEL_WIDTH + 2);
  localparam logic REG_ROTATION = 1'b0;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RMW, S_DATA} state_t;

  state_t          state;
  logic [1:0]      rotation;
  logic [AW-1:0]   clr_addr;
  logic [PG_W-1:0] page;
  logic [OFF_W-1:0] off;
  logic [AW-1:0]   byte_addr;
  logic [AW-1:0]   rmw_addr;
  logic [2:0]      rmw_bit;
  logic            rmw_color;

  logic [7:0]      mem [STORE_SIZE];
  logic [7:0]      rd_data;
  logic [AW-1:0]   mem_addr;
  logic            mem_we;
  logic [7:0]      mem_wdata;

  pix_loc_t        loc;
  logic [AW-1:0]   pix_addr;
  logic            accept;
  logic            load_ok;
  logic            frame_tail;
  logic            beat_now;

  mpfb_map #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_map (
    .rotation(rotation),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .loc     (loc),
    .addr    (pix_addr)
  );

  // configuration
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ROTATION) begin
      prdata = 32'(rotation);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROTATION) begin
      rotation <= pwdata[1:0];
    end
  end

  // item handshake
  assign req_ready  = (state == S_IDLE) &&
                      (!spi_valid || spi_ready || cmd != CMD_REFRESH);
  assign accept     = req_valid && req_ready;
  assign load_ok    = (32'(byte_index) < 32'(STORE_SIZE));
  assign frame_tail = (page == PG_W'(PAGE_COUNT));

  // a new refresh byte is loaded onto spi_* this cycle
  assign beat_now   = (state == S_DATA) ||
                      (accept && cmd == CMD_REFRESH &&
                       (frame_tail || off == '0 || off == OFF_W'(1)));

  // store port
  always_comb begin
    mem_addr  = '0;
    mem_we    = 1'b0;
    mem_wdata = byte_value;
    unique case (state)
      S_CLEAR: begin
        mem_addr  = clr_addr;
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_RMW: begin
        mem_addr  = rmw_addr;
        mem_we    = 1'b1;
        mem_wdata = rmw_color ? (rd_data | (8'd1 << rmw_bit))
                              : (rd_data & ~(8'd1 << rmw_bit));
      end
      S_IDLE: begin
        if (cmd == CMD_DRAW) begin
          mem_addr = pix_addr;
        end else if (cmd == CMD_LOAD) begin
          mem_addr = AW'(byte_index);
          mem_we   = accept && load_ok;
        end else begin
          mem_addr = byte_addr;
        end
      end
      default: begin
        mem_addr = byte_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      page      <= '0;
      off       <= '0;
      byte_addr <= '0;
      spi_valid <= 1'b0;
    end else begin
      if (spi_valid && spi_ready && !beat_now) begin
        spi_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(STORE_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && cmd == CMD_DRAW && loc.hit) begin
            rmw_addr  <= pix_addr;
            rmw_bit   <= loc.row_bit;
            rmw_color <= color;
            state     <= S_RMW;
          end
          if (accept && cmd == CMD_REFRESH) begin
            if (frame_tail) begin
              spi_valid  <= 1'b1;
              spi_byte   <= LCD_ROW_ADDR;
              is_data    <= 1'b0;
              frame_last <= 1'b1;
              page       <= '0;
              off        <= '0;
              byte_addr  <= '0;
            end else begin
              if (off == OFF_W'(PANEL_WIDTH + 1)) begin
                off  <= '0;
                page <= page + 1'b1;
              end else begin
                off <= off + 1'b1;
              end
              if (off == '0) begin
                spi_valid  <= 1'b1;
                spi_byte   <= LCD_ROW_ADDR | 8'(page);
                is_data    <= 1'b0;
                frame_last <= 1'b0;
              end else if (off == OFF_W'(1)) begin
                spi_valid  <= 1'b1;
                spi_byte   <= LCD_COL_ADDR;
                is_data    <= 1'b0;
                frame_last <= 1'b0;
              end else begin
                byte_addr <= byte_addr + 1'b1;
                state     <= S_DATA;
              end
            end
          end
        end
        S_RMW: begin
          state <= S_IDLE;
        end
        S_DATA: begin
          spi_valid  <= 1'b1;
          spi_byte   <= rd_data;
          is_data    <= 1'b1;
          frame_last <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
